@@ rtl/core/gbmw_pkg.sv @@
// ----------------------------------------------------------------------------
// gbmw_pkg
// Types and constants for the masked-write GPIO bank with interrupt.
// ----------------------------------------------------------------------------
package gbmw_pkg;

  localparam int unsigned PinCountDefault = 16;
  localparam int unsigned BankWidth       = 16;
  localparam int unsigned KindWidth       = 2;
  localparam int unsigned SelWidth        = 4;
  localparam int unsigned WordWidth       = 32;
  localparam int unsigned MaskLsb         = 16;

  typedef enum logic [KindWidth-1:0] {
    KIND_IDLE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [SelWidth-1:0] {
    REG_OE     = 4'd0,
    REG_OUT    = 4'd1,
    REG_IN     = 4'd2,
    REG_POL    = 4'd3,
    REG_TYPE   = 4'd4,
    REG_IEN    = 4'd5,
    REG_STAT   = 4'd6,
    REG_MSEL   = 4'd7,
    REG_PULLUP = 4'd8
  } reg_sel_e;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    logic [SelWidth-1:0]  reg_select;
    logic [WordWidth-1:0] write_word;
    logic [BankWidth-1:0] pin_levels;
  } item_t;

  typedef struct packed {
    logic [BankWidth-1:0] read_word;
    logic [BankWidth-1:0] drive_levels;
    logic [BankWidth-1:0] drive_enables;
    logic [BankWidth-1:0] gpio_owned;
    logic [BankWidth-1:0] pullup_enables;
    logic                 bank_interrupt;
  } result_t;

endpackage

@@ rtl/core/gbmw_in_if.sv @@
// ----------------------------------------------------------------------------
// gbmw_in_if
// Access channel: one bus access or idle tick plus the pin samples per item.
// ----------------------------------------------------------------------------
interface gbmw_in_if
  import gbmw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [KindWidth-1:0] kind;
  logic [SelWidth-1:0]  reg_select;
  logic [WordWidth-1:0] write_word;
  logic [BankWidth-1:0] pin_levels;

  modport source (output valid, kind, reg_select, write_word, pin_levels, input ready);
  modport sink   (input valid, kind, reg_select, write_word, pin_levels, output ready);
endinterface

@@ rtl/core/gbmw_out_if.sv @@
// ----------------------------------------------------------------------------
// gbmw_out_if
// Result channel: read data, pin drive state and the bank interrupt.
// ----------------------------------------------------------------------------
interface gbmw_out_if
  import gbmw_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BankWidth-1:0] read_word;
  logic [BankWidth-1:0] drive_levels;
  logic [BankWidth-1:0] drive_enables;
  logic [BankWidth-1:0] gpio_owned;
  logic [BankWidth-1:0] pullup_enables;
  logic                 bank_interrupt;

  modport source (output valid, read_word, drive_levels, drive_enables, gpio_owned,
                  pullup_enables, bank_interrupt, input ready);
  modport sink   (input valid, read_word, drive_levels, drive_enables, gpio_owned,
                  pullup_enables, bank_interrupt, output ready);
endinterface

@@ rtl/core/gbmw_in_stage.sv @@
// ----------------------------------------------------------------------------
// gbmw_in_stage
// Input register: captures one item and holds it until it advances.
// ----------------------------------------------------------------------------
module gbmw_in_stage
  import gbmw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  // Take a new item when empty or when the held one leaves this cycle.
  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

`ifndef SYNTHESIS
  a_adv_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |-> valid_q)
    else $error("gbmw_in_stage: advance without a held item");
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !advance_i) |=> (valid_q && $stable(item_q)))
    else $error("gbmw_in_stage: held item lost while stalled");
  a_fill_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ready_o && valid_i) |=> valid_q)
    else $error("gbmw_in_stage: accepted item not held");
`endif

endmodule

@@ rtl/core/gbmw_regs.sv @@
// ----------------------------------------------------------------------------
// gbmw_regs
// Register bank: read mux, masked writes, status capture and interrupt.
// ----------------------------------------------------------------------------
module gbmw_regs
  import gbmw_pkg::*;
#(
  parameter int unsigned PIN_COUNT = PinCountDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  output result_t result_o
);

  logic [PIN_COUNT-1:0] oe_q, out_q, pol_q, type_q, ien_q, stat_q, msel_q, pull_q, prev_q;
  logic [PIN_COUNT-1:0] oe_d, out_d, pol_d, type_d, ien_d, stat_d, msel_d, pull_d;
  logic [PIN_COUNT-1:0] pins, wr_mask, wr_val, stat_wr;
  logic [PIN_COUNT-1:0] at_pol, changed, level_set, edge_set;
  logic [BankWidth-1:0] rd_word;
  logic                 is_write;

  assign pins     = item_i.pin_levels[PIN_COUNT-1:0];
  assign wr_mask  = item_i.write_word[MaskLsb +: PIN_COUNT];
  assign wr_val   = item_i.write_word[PIN_COUNT-1:0];
  assign is_write = (item_i.kind == KIND_WRITE);

  // Read sees the registers as they stood before this item.
  always_comb begin
    rd_word = '0;
    if (item_i.kind == KIND_READ) begin
      unique case (item_i.reg_select)
        REG_OE:     rd_word = BankWidth'(oe_q);
        REG_OUT:    rd_word = BankWidth'(out_q);
        REG_IN:     rd_word = BankWidth'(pins);
        REG_POL:    rd_word = BankWidth'(pol_q);
        REG_TYPE:   rd_word = BankWidth'(type_q);
        REG_IEN:    rd_word = BankWidth'(ien_q);
        REG_STAT:   rd_word = BankWidth'(stat_q);
        REG_MSEL:   rd_word = BankWidth'(msel_q);
        REG_PULLUP: rd_word = BankWidth'(pull_q);
        default:    rd_word = '0;
      endcase
    end
  end

  always_comb begin
    oe_d    = oe_q;
    out_d   = out_q;
    pol_d   = pol_q;
    type_d  = type_q;
    ien_d   = ien_q;
    stat_wr = stat_q;
    msel_d  = msel_q;
    pull_d  = pull_q;
    if (is_write) begin
      unique case (item_i.reg_select)
        REG_OE:     oe_d    = (oe_q & ~wr_mask) | (wr_val & wr_mask);
        REG_OUT:    out_d   = (out_q & ~wr_mask) | (wr_val & wr_mask);
        REG_POL:    pol_d   = (pol_q & ~wr_mask) | (wr_val & wr_mask);
        REG_TYPE:   type_d  = (type_q & ~wr_mask) | (wr_val & wr_mask);
        REG_IEN:    ien_d   = (ien_q & ~wr_mask) | (wr_val & wr_mask);
        REG_STAT:   stat_wr = stat_q & ~wr_mask;
        REG_MSEL:   msel_d  = (msel_q & ~wr_mask) | (wr_val & wr_mask);
        REG_PULLUP: pull_d  = (pull_q & ~wr_mask) | (wr_val & wr_mask);
        default:    ;
      endcase
    end
  end

  // Capture uses polarity and type after this item's write; set beats clear.
  assign at_pol    = ~(pins ^ pol_d);
  assign changed   = pins ^ prev_q;
  assign level_set = at_pol & ~type_d;
  assign edge_set  = at_pol & changed & type_d;
  assign stat_d    = stat_wr | level_set | edge_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oe_q   <= '0;
      out_q  <= '0;
      pol_q  <= '0;
      type_q <= '0;
      ien_q  <= '0;
      stat_q <= '0;
      msel_q <= '0;
      pull_q <= '0;
      prev_q <= '0;
    end else if (advance_i) begin
      oe_q   <= oe_d;
      out_q  <= out_d;
      pol_q  <= pol_d;
      type_q <= type_d;
      ien_q  <= ien_d;
      stat_q <= stat_d;
      msel_q <= msel_d;
      pull_q <= pull_d;
      prev_q <= pins;
    end
  end

  always_comb begin
    result_o.read_word      = rd_word;
    result_o.drive_levels   = BankWidth'(out_d);
    result_o.drive_enables  = BankWidth'(oe_d);
    result_o.gpio_owned     = BankWidth'(msel_d);
    result_o.pullup_enables = BankWidth'(pull_d);
    result_o.bank_interrupt = |(stat_d & ien_d & ~oe_d);
  end

`ifndef SYNTHESIS
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> ($stable(stat_q) && $stable(oe_q) && $stable(prev_q)))
    else $error("gbmw_regs: state changed without an item");
  a_level_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |=> ((stat_q & $past(level_set)) == $past(level_set)))
    else $error("gbmw_regs: level match did not set status");
  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |=> (prev_q == $past(pins)))
    else $error("gbmw_regs: previous pin sample not updated");
  a_read_side_effect_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !is_write) |=> ($stable(oe_q) && $stable(out_q) && $stable(ien_q)))
    else $error("gbmw_regs: register changed without a write");
`endif

endmodule

@@ rtl/core/gpio_bank_masked_write_irq.sv @@
// ----------------------------------------------------------------------------
// gpio_bank_masked_write_irq
// GPIO bank with masked register writes, pin status capture and interrupt.
// ----------------------------------------------------------------------------
//  port     | dir | carries
//  item_i   | in  | kind, reg_select, write_word, pin_levels
//  result_o | out | read_word, drive levels/enables, ownership, pullups, irq
//
//  The result is valid once the item has passed the input register and then the
//  result register; one item per cycle sustained while the result is taken, set by
//  the single input register and result register pair.
//  All register bank state updates as an item moves into the result register.
//  Reset clears every bank register and the previous pin sample to zero.
//  A stalled result holds the input register; item_i.ready drops only when
//  both registers are full and the result is not taken.
// ----------------------------------------------------------------------------
module gpio_bank_masked_write_irq
  import gbmw_pkg::*;
#(
  parameter int unsigned PIN_COUNT = PinCountDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  gbmw_in_if.sink         item_i,
  gbmw_out_if.source      result_o
);

  item_t   in_item, s1_item;
  result_t res_d, res_q;
  logic    s1_valid, advance, out_valid_q;

  assign in_item.kind       = item_i.kind;
  assign in_item.reg_select = item_i.reg_select;
  assign in_item.write_word = item_i.write_word;
  assign in_item.pin_levels = item_i.pin_levels;

  // Move the held item on when the result register is free or being drained.
  assign advance = s1_valid && (!out_valid_q || result_o.ready);

  gbmw_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (item_i.valid),
    .ready_o   (item_i.ready),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  gbmw_regs #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.read_word      = res_q.read_word;
  assign result_o.drive_levels   = res_q.drive_levels;
  assign result_o.drive_enables  = res_q.drive_enables;
  assign result_o.gpio_owned     = res_q.gpio_owned;
  assign result_o.pullup_enables = res_q.pullup_enables;
  assign result_o.bank_interrupt = res_q.bank_interrupt;

`ifndef SYNTHESIS
  a_backpressure_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_i.ready |-> (s1_valid && out_valid_q && !result_o.ready))
    else $error("top: input stalled while a stage had room");
  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("top: result appeared without an item advancing");
  a_result_stable_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> $stable(res_q))
    else $error("top: stalled result overwritten");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the masked-write GPIO bank against a cycle-free shadow of its
// registers. Every accepted access updates the shadow and queues the output
// word it must produce; every output word taken from the bank is compared
// field by field with the oldest queued one. Directed accesses cover the
// corner cases, then random traffic runs under three idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import gbmw_pkg::*;

  localparam logic [KindWidth-1:0] KindReserved = 2'd3;
  localparam logic [SelWidth-1:0]  RegUnusedLo  = 4'd9;
  localparam logic [SelWidth-1:0]  RegUnusedHi  = 4'd15;
  localparam logic [BankWidth-1:0] AllPins      = 16'hFFFF;
  localparam logic [BankWidth-1:0] NoPins       = 16'h0000;
  localparam int unsigned          CycleLimit   = 100000;
  localparam int unsigned          RandomPerPhase = 125;

  // Shadow of the bank: register state plus the output words still owed.
  class gpio_bank_shadow;
    logic [BankWidth-1:0] oe_bits, out_bits, pol_bits, type_bits;
    logic [BankWidth-1:0] ien_bits, stat_bits, msel_bits, pullup_bits, last_pins;
    result_t pending_outputs[$];
    int unsigned mismatches, compared, reads, writes, accesses;

    function new();
      oe_bits = '0;   out_bits = '0;  pol_bits = '0;    type_bits = '0;
      ien_bits = '0;  stat_bits = '0; msel_bits = '0;   pullup_bits = '0;
      last_pins = '0;
      mismatches = 0; compared = 0; reads = 0; writes = 0; accesses = 0;
    endfunction

    function automatic logic [BankWidth-1:0] merge(logic [BankWidth-1:0] old_bits,
                                                   logic [BankWidth-1:0] mask,
                                                   logic [BankWidth-1:0] vals);
      return (old_bits & ~mask) | (vals & mask);
    endfunction

    function void note_access(item_t acc);
      logic [BankWidth-1:0] rd, mask, vals, at_pol, changed;
      result_t want;
      rd = '0;
      mask = acc.write_word[WordWidth-1:MaskLsb];
      vals = acc.write_word[MaskLsb-1:0];
      accesses++;
      // read sees the registers as they were before this item
      if (acc.kind == KIND_READ) begin
        reads++;
        case (acc.reg_select)
          REG_OE:     rd = oe_bits;
          REG_OUT:    rd = out_bits;
          REG_IN:     rd = acc.pin_levels;
          REG_POL:    rd = pol_bits;
          REG_TYPE:   rd = type_bits;
          REG_IEN:    rd = ien_bits;
          REG_STAT:   rd = stat_bits;
          REG_MSEL:   rd = msel_bits;
          REG_PULLUP: rd = pullup_bits;
          default:    rd = '0;
        endcase
      end else if (acc.kind == KIND_WRITE) begin
        writes++;
        case (acc.reg_select)
          REG_OE:     oe_bits = merge(oe_bits, mask, vals);
          REG_OUT:    out_bits = merge(out_bits, mask, vals);
          REG_POL:    pol_bits = merge(pol_bits, mask, vals);
          REG_TYPE:   type_bits = merge(type_bits, mask, vals);
          REG_IEN:    ien_bits = merge(ien_bits, mask, vals);
          REG_STAT:   stat_bits = stat_bits & ~mask;
          REG_MSEL:   msel_bits = merge(msel_bits, mask, vals);
          REG_PULLUP: pullup_bits = merge(pullup_bits, mask, vals);
          default:    ;
        endcase
      end
      // pin capture comes after the write, so a set in the same item wins
      at_pol  = ~(acc.pin_levels ^ pol_bits);
      changed = acc.pin_levels ^ last_pins;
      stat_bits = stat_bits | (at_pol & ~type_bits) | (at_pol & changed & type_bits);
      last_pins = acc.pin_levels;

      want.read_word      = rd;
      want.drive_levels   = out_bits;
      want.drive_enables  = oe_bits;
      want.gpio_owned     = msel_bits;
      want.pullup_enables = pullup_bits;
      want.bank_interrupt = |(stat_bits & ien_bits & ~oe_bits);
      pending_outputs.push_back(want);
    endfunction

    function void compare_field(string field, logic [BankWidth-1:0] want,
                                logic [BankWidth-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: output word with nothing expected, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_outputs.pop_front();
      compared++;
      compare_field("read_word", want.read_word, got.read_word);
      compare_field("drive_levels", want.drive_levels, got.drive_levels);
      compare_field("drive_enables", want.drive_enables, got.drive_enables);
      compare_field("gpio_owned", want.gpio_owned, got.gpio_owned);
      compare_field("pullup_enables", want.pullup_enables, got.pullup_enables);
      compare_field("bank_interrupt", 16'(want.bank_interrupt), 16'(got.bank_interrupt));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  gbmw_in_if  access_if();
  gbmw_out_if result_if();

  gpio_bank_masked_write_irq #(
    .PIN_COUNT(16)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (access_if),
    .result_o(result_if)
  );

  gpio_bank_shadow shadow;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned cycle_count;
  logic [BankWidth-1:0] pins_sent;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Receiver: take an output word at each edge where valid and ready meet.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        shadow.check_result('{read_word:      result_if.read_word,
                              drive_levels:   result_if.drive_levels,
                              drive_enables:  result_if.drive_enables,
                              gpio_owned:     result_if.gpio_owned,
                              pullup_enables: result_if.pullup_enables,
                              bank_interrupt: result_if.bank_interrupt});
      end
      result_if.ready <= rst_ni && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic item_t make_access(logic [KindWidth-1:0] kind,
                                        logic [SelWidth-1:0] sel,
                                        logic [BankWidth-1:0] mask,
                                        logic [BankWidth-1:0] vals,
                                        logic [BankWidth-1:0] pins);
    item_t acc;
    acc.kind       = kind;
    acc.reg_select = sel;
    acc.write_word = {mask, vals};
    acc.pin_levels = pins;
    return acc;
  endfunction

  task automatic issue_access(input item_t acc);
    while ($urandom_range(99) < src_idle_pct) begin
      access_if.valid <= 1'b0;
      access_if.write_word <= $urandom;
      @(posedge clk_i);
    end
    access_if.valid      <= 1'b1;
    access_if.kind       <= acc.kind;
    access_if.reg_select <= acc.reg_select;
    access_if.write_word <= acc.write_word;
    access_if.pin_levels <= acc.pin_levels;
    do @(posedge clk_i); while (access_if.ready !== 1'b1);
    shadow.note_access(acc);
    pins_sent = acc.pin_levels;
  endtask

  // Hold the access channel low until the bank has returned everything.
  task automatic wait_drained();
    access_if.valid <= 1'b0;
    while (shadow.pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random_phase(input int unsigned count);
    logic [KindWidth-1:0] kind;
    logic [SelWidth-1:0] sel;
    logic [BankWidth-1:0] mask, pins;
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 15)      kind = KIND_IDLE;
      else if (roll < 20) kind = KindReserved;
      else if (roll < 55) kind = KIND_READ;
      else                kind = KIND_WRITE;
      if ($urandom_range(99) < 8) sel = SelWidth'($urandom_range(RegUnusedHi, RegUnusedLo));
      else                        sel = SelWidth'($urandom_range(REG_PULLUP, REG_OE));
      case ($urandom_range(3))
        0:       mask = AllPins;
        1:       mask = 16'h1 << $urandom_range(BankWidth - 1);
        default: mask = BankWidth'($urandom);
      endcase
      // half the time flip a single pin so edge mode sees both clean edges and holds
      case ($urandom_range(3))
        0:       pins = BankWidth'($urandom);
        1:       pins = pins_sent;
        default: pins = pins_sent ^ (16'h1 << $urandom_range(BankWidth - 1));
      endcase
      issue_access(make_access(kind, sel, mask, BankWidth'($urandom), pins));
    end
  endtask

  initial begin
    shadow = new();
    src_idle_pct  = 9;
    sink_idle_pct = 79;
    pins_sent = '0;
    rst_ni = 1'b0;
    access_if.valid      = 1'b0;
    access_if.kind       = KIND_IDLE;
    access_if.reg_select = REG_OE;
    access_if.write_word = '0;
    access_if.pin_levels = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge mode with pins held low, so the first high sample is a rising edge
    issue_access(make_access(KIND_WRITE, REG_POL, AllPins, AllPins, NoPins));
    issue_access(make_access(KIND_WRITE, REG_TYPE, AllPins, AllPins, NoPins));
    issue_access(make_access(KIND_READ, REG_STAT, NoPins, NoPins, AllPins));
    issue_access(make_access(KIND_READ, REG_STAT, NoPins, NoPins, AllPins));
    issue_access(make_access(KIND_WRITE, REG_IEN, AllPins, AllPins, AllPins));
    // driven pins mask the interrupt
    issue_access(make_access(KIND_WRITE, REG_OE, AllPins, AllPins, AllPins));
    issue_access(make_access(KIND_WRITE, REG_OE, AllPins, NoPins, AllPins));
    issue_access(make_access(KIND_WRITE, REG_STAT, AllPins, NoPins, NoPins));
    // level mode: clear and set in the same item, set wins
    issue_access(make_access(KIND_WRITE, REG_TYPE, AllPins, NoPins, NoPins));
    issue_access(make_access(KIND_WRITE, REG_STAT, AllPins, AllPins, AllPins));
    issue_access(make_access(KIND_READ, REG_STAT, NoPins, NoPins, NoPins));
    // input register is read-only and reads this item's pins
    issue_access(make_access(KIND_WRITE, REG_IN, AllPins, AllPins, 16'h5A5A));
    issue_access(make_access(KIND_READ, REG_IN, NoPins, NoPins, 16'hA5A5));
    issue_access(make_access(KIND_WRITE, RegUnusedLo, AllPins, AllPins, AllPins));
    issue_access(make_access(KIND_READ, RegUnusedHi, AllPins, AllPins, AllPins));
    issue_access(make_access(KindReserved, REG_OUT, AllPins, AllPins, NoPins));
    issue_access(make_access(KIND_WRITE, REG_OUT, AllPins, AllPins, NoPins));
    issue_access(make_access(KIND_WRITE, REG_OUT, 16'h00FF, NoPins, NoPins));
    issue_access(make_access(KIND_WRITE, REG_OUT, NoPins, NoPins, NoPins));
    issue_access(make_access(KIND_WRITE, REG_MSEL, AllPins, AllPins, AllPins));
    issue_access(make_access(KIND_WRITE, REG_PULLUP, AllPins, AllPins, NoPins));
    issue_access(make_access(KIND_READ, REG_MSEL, NoPins, NoPins, AllPins));
    issue_access(make_access(KIND_READ, REG_PULLUP, NoPins, NoPins, NoPins));
    issue_access(make_access(KIND_WRITE, REG_POL, AllPins, NoPins, NoPins));
    issue_access(make_access(KIND_READ, REG_POL, NoPins, NoPins, AllPins));

    run_random_phase(RandomPerPhase);
    wait_drained();
    src_idle_pct  = 79;
    sink_idle_pct = 9;
    run_random_phase(RandomPerPhase);
    wait_drained();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random_phase(RandomPerPhase);
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d accesses (%0d reads, %0d writes) and compared %0d output words,",
             shadow.accesses, shadow.reads, shadow.writes, shadow.compared);
    $display("under sender-heavy, receiver-heavy and no idling, with %0d mismatches.",
             shadow.mismatches);
    if (shadow.mismatches == 0 && shadow.pending_outputs.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ gpio_bank_masked_write_irq.f @@
rtl/core/gbmw_pkg.sv
rtl/core/gbmw_in_if.sv
rtl/core/gbmw_out_if.sv
rtl/core/gbmw_in_stage.sv
rtl/core/gbmw_regs.sv
rtl/core/gpio_bank_masked_write_irq.sv
test/testbench.sv
